// ===== hdl/spot_pkg.sv =====
// shared constants and types for the shape pair overlap test
package spot_pkg;

    localparam int COORD_WIDTH = 16;

    localparam int KIND_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [KIND_WIDTH-1:0] t_kind;

    localparam t_kind KIND_NONE     = 3'd0;
    localparam t_kind KIND_RECT     = 3'd1;
    localparam t_kind KIND_CIRCLE   = 3'd2;
    localparam t_kind KIND_TRIANGLE = 3'd3;
    localparam t_kind KIND_POLYGON  = 3'd4;

endpackage

// ===== hdl/shape_pair_overlap_test_unit.sv =====
// top level of the shape pair overlap test
//
// one request carries two shape kinds and their coordinate slots; the block
// answers with one overlap bit per request
// request channel: a request is taken at a rising edge with start high and
// busy low; busy stays low, so a request can be taken at every edge
// result channel: o_result_valid is high for exactly one cycle with
// o_overlap; the receiver takes it at the edge that ends that cycle and
// cannot hold it off
// path: a request passes the input register, then the compare logic, then the
// result register before it is shown
// throughput: one request per cycle, set by the single pass of the
// multipliers of the triangle edge and squared distance tests
// reset: synchronous, active low; drops any request in flight, no result
// is shown for it
module shape_pair_overlap_test_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  spot_pkg::t_kind  i_shape_a_kind,
    input  spot_pkg::t_kind  i_shape_b_kind,
    input  spot_pkg::t_coord i_a_p0,
    input  spot_pkg::t_coord i_a_p1,
    input  spot_pkg::t_coord i_a_p2,
    input  spot_pkg::t_coord i_a_p3,
    input  spot_pkg::t_coord i_a_p4,
    input  spot_pkg::t_coord i_a_p5,
    input  spot_pkg::t_coord i_b_p0,
    input  spot_pkg::t_coord i_b_p1,
    input  spot_pkg::t_coord i_b_p2,
    input  spot_pkg::t_coord i_b_p3,
    output logic             o_result_valid,
    output logic             o_overlap
);

    logic             r_in_valid;
    logic             n_in_valid;
    spot_pkg::t_kind  r_ka;
    spot_pkg::t_kind  r_kb;
    spot_pkg::t_coord r_a [6];
    spot_pkg::t_coord r_b [4];
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_overlap;
    logic             n_overlap;

    spot_pkg::t_coord a4 [4];
    spot_pkg::t_coord s_sel [4];
    spot_pkg::t_coord c_sel [3];
    logic             cc_mode;
    logic             hit_rr;
    logic             hit_circ;
    logic             hit_tri;

    assign busy       = 1'b0;
    assign n_in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_ka   <= i_shape_a_kind;
            r_kb   <= i_shape_b_kind;
            r_a[0] <= i_a_p0;
            r_a[1] <= i_a_p1;
            r_a[2] <= i_a_p2;
            r_a[3] <= i_a_p3;
            r_a[4] <= i_a_p4;
            r_a[5] <= i_a_p5;
            r_b[0] <= i_b_p0;
            r_b[1] <= i_b_p1;
            r_b[2] <= i_b_p2;
            r_b[3] <= i_b_p3;
        end
    end

    // rect goes to the s side, circle to the c side; circle-circle puts b on s
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a4[i]    = r_a[i];
            s_sel[i] = (r_ka == spot_pkg::KIND_RECT) ? r_a[i] : r_b[i];
        end
        for (int i = 0; i < 3; i++) begin
            c_sel[i] = (r_ka == spot_pkg::KIND_RECT) ? r_b[i] : r_a[i];
        end
        cc_mode = (r_ka == spot_pkg::KIND_CIRCLE) && (r_kb == spot_pkg::KIND_CIRCLE);
    end

    spot_rect_rect u_rect_rect (
        .i_a   (a4),
        .i_b   (r_b),
        .o_hit (hit_rr)
    );

    spot_circ u_circ (
        .i_cc  (cc_mode),
        .i_s   (s_sel),
        .i_c   (c_sel),
        .o_hit (hit_circ)
    );

    spot_tri u_tri (
        .i_t   (r_a),
        .i_r   (r_b),
        .o_hit (hit_tri)
    );

    always_comb begin
        n_out_valid = r_in_valid;
        priority if (r_ka == spot_pkg::KIND_RECT && r_kb == spot_pkg::KIND_RECT) begin
            n_overlap = hit_rr;
        end else if (r_ka == spot_pkg::KIND_CIRCLE && r_kb == spot_pkg::KIND_CIRCLE) begin
            n_overlap = hit_circ;
        end else if (r_ka == spot_pkg::KIND_RECT && r_kb == spot_pkg::KIND_CIRCLE) begin
            n_overlap = hit_circ;
        end else if (r_ka == spot_pkg::KIND_CIRCLE && r_kb == spot_pkg::KIND_RECT) begin
            n_overlap = hit_circ;
        end else if (r_ka == spot_pkg::KIND_TRIANGLE && r_kb == spot_pkg::KIND_RECT) begin
            n_overlap = hit_tri;
        end else begin
            n_overlap = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_overlap      = r_overlap;

endmodule

// ===== hdl/spot_rect_rect.sv =====
// strict axis-aligned box against box test
module spot_rect_rect (
    input  spot_pkg::t_coord i_a [4],
    input  spot_pkg::t_coord i_b [4],
    output logic             o_hit
);

    localparam int W = spot_pkg::COORD_WIDTH;

    logic signed [W:0] a_x_hi;
    logic signed [W:0] a_y_hi;
    logic signed [W:0] b_x_hi;
    logic signed [W:0] b_y_hi;
    logic signed [W:0] a_x;
    logic signed [W:0] a_y;
    logic signed [W:0] b_x;
    logic signed [W:0] b_y;

    always_comb begin
        a_x    = (W+1)'(i_a[0]);
        a_y    = (W+1)'(i_a[1]);
        b_x    = (W+1)'(i_b[0]);
        b_y    = (W+1)'(i_b[1]);
        a_x_hi = a_x + (W+1)'(i_a[2]);
        a_y_hi = a_y + (W+1)'(i_a[3]);
        b_x_hi = b_x + (W+1)'(i_b[2]);
        b_y_hi = b_y + (W+1)'(i_b[3]);
        o_hit  = (a_x < b_x_hi) && (a_x_hi > b_x) && (a_y < b_y_hi) && (a_y_hi > b_y);
    end

endmodule

// ===== hdl/spot_circ.sv =====
// squared distance test shared by circle-circle and rect-circle
module spot_circ (
    input  logic             i_cc,
    input  spot_pkg::t_coord i_s [4],
    input  spot_pkg::t_coord i_c [3],
    output logic             o_hit
);

    localparam int W = spot_pkg::COORD_WIDTH;

    logic signed [W:0]     c_x;
    logic signed [W:0]     c_y;
    logic signed [W:0]     s_x;
    logic signed [W:0]     s_y;
    logic signed [W:0]     x_hi;
    logic signed [W:0]     y_hi;
    logic signed [W:0]     x_min;
    logic signed [W:0]     y_min;
    logic signed [W:0]     n_x;
    logic signed [W:0]     n_y;
    logic signed [W:0]     rad;
    logic signed [W+1:0]   d_x;
    logic signed [W+1:0]   d_y;
    logic signed [2*W+3:0] sq_x;
    logic signed [2*W+3:0] sq_y;
    logic signed [2*W+4:0] d_sq;
    logic signed [2*W+1:0] rad_sq;

    always_comb begin
        c_x   = (W+1)'(i_c[0]);
        c_y   = (W+1)'(i_c[1]);
        s_x   = (W+1)'(i_s[0]);
        s_y   = (W+1)'(i_s[1]);
        x_hi  = s_x + (W+1)'(i_s[2]);
        y_hi  = s_y + (W+1)'(i_s[3]);
        // clamp circle center onto the rect
        x_min = (c_x < x_hi) ? c_x : x_hi;
        y_min = (c_y < y_hi) ? c_y : y_hi;
        if (i_cc) begin
            n_x = s_x;
            n_y = s_y;
            rad = (W+1)'(i_c[2]) + (W+1)'(i_s[2]);
        end else begin
            n_x = (s_x > x_min) ? s_x : x_min;
            n_y = (s_y > y_min) ? s_y : y_min;
            rad = (W+1)'(i_c[2]);
        end
        d_x    = (W+2)'(c_x) - (W+2)'(n_x);
        d_y    = (W+2)'(c_y) - (W+2)'(n_y);
        sq_x   = d_x * d_x;
        sq_y   = d_y * d_y;
        rad_sq = rad * rad;
        d_sq   = (2*W+5)'(sq_x) + (2*W+5)'(sq_y);
        o_hit  = d_sq < (2*W+5)'(rad_sq);
    end

endmodule

// ===== hdl/spot_tri.sv =====
// rect center inside triangle test on doubled coordinates
module spot_tri (
    input  spot_pkg::t_coord i_t [6],
    input  spot_pkg::t_coord i_r [4],
    output logic             o_hit
);

    localparam int W = spot_pkg::COORD_WIDTH;

    logic signed [W+1:0]   p_x;
    logic signed [W+1:0]   p_y;
    logic signed [W+1:0]   v_x   [3];
    logic signed [W+1:0]   v_y   [3];
    logic signed [W+2:0]   dp_x  [3];
    logic signed [W+2:0]   dp_y  [3];
    logic signed [W+2:0]   dq_x  [3];
    logic signed [W+2:0]   dq_y  [3];
    logic signed [2*W+5:0] pr_a  [3];
    logic signed [2*W+5:0] pr_b  [3];
    logic signed [2*W+6:0] e     [3];
    logic [2:0]            e_neg;
    logic [2:0]            e_pos;

    always_comb begin
        p_x = ((W+2)'(i_r[0]) <<< 1) + (W+2)'(i_r[2]);
        p_y = ((W+2)'(i_r[1]) <<< 1) + (W+2)'(i_r[3]);
        for (int i = 0; i < 3; i++) begin
            v_x[i] = (W+2)'(i_t[2*i]) <<< 1;
            v_y[i] = (W+2)'(i_t[2*i+1]) <<< 1;
        end
        // edge i runs from vertex i to vertex i+1, sign taken about vertex i+1
        for (int i = 0; i < 3; i++) begin
            dp_x[i]  = (W+3)'(p_x) - (W+3)'(v_x[(i+1)%3]);
            dp_y[i]  = (W+3)'(p_y) - (W+3)'(v_y[(i+1)%3]);
            dq_x[i]  = (W+3)'(v_x[i]) - (W+3)'(v_x[(i+1)%3]);
            dq_y[i]  = (W+3)'(v_y[i]) - (W+3)'(v_y[(i+1)%3]);
            pr_a[i]  = dp_x[i] * dq_y[i];
            pr_b[i]  = dq_x[i] * dp_y[i];
            e[i]     = (2*W+7)'(pr_a[i]) - (2*W+7)'(pr_b[i]);
            e_neg[i] = e[i][2*W+6];
            e_pos[i] = !e[i][2*W+6] && (e[i] != '0);
        end
        o_hit = !((|e_neg) && (|e_pos));
    end

endmodule

// ===== hdl/spot_checker.sv =====
// port level assertions for the shape pair overlap test, bound to the top level
module spot_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input spot_pkg::t_kind i_shape_a_kind,
    input spot_pkg::t_kind i_shape_b_kind,
    input logic            o_result_valid,
    input logic            o_overlap
);

    logic req;
    logic no_pair;

    assign req     = i_rst_n && start && !busy;
    assign no_pair = (i_shape_a_kind == spot_pkg::KIND_NONE)
                  || (i_shape_a_kind == spot_pkg::KIND_POLYGON)
                  || (i_shape_b_kind == spot_pkg::KIND_NONE)
                  || (i_shape_b_kind == spot_pkg::KIND_POLYGON)
                  || (i_shape_b_kind == spot_pkg::KIND_TRIANGLE);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req |-> ##2 o_result_valid)
        else $error("request without result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(req, 2))
        else $error("result without request");

    a_unsupported_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req && no_pair) |-> ##2 !o_overlap)
        else $error("overlap reported for unsupported pairing");

endmodule

bind shape_pair_overlap_test_unit spot_checker u_spot_checker (.*);

// ===== test/tb_shape_pair_overlap_test_unit.sv =====
// self-checking testbench for the shape pair overlap test unit
module tb_shape_pair_overlap_test_unit;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int CW          = spot_pkg::COORD_WIDTH;

    typedef struct packed {
        spot_pkg::t_kind    kind_a;
        spot_pkg::t_kind    kind_b;
        logic [5:0][CW-1:0] a;
        logic [3:0][CW-1:0] b;
    } t_shape_pair;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    spot_pkg::t_kind  i_shape_a_kind = spot_pkg::KIND_NONE;
    spot_pkg::t_kind  i_shape_b_kind = spot_pkg::KIND_NONE;
    spot_pkg::t_coord i_a_p0 = '0;
    spot_pkg::t_coord i_a_p1 = '0;
    spot_pkg::t_coord i_a_p2 = '0;
    spot_pkg::t_coord i_a_p3 = '0;
    spot_pkg::t_coord i_a_p4 = '0;
    spot_pkg::t_coord i_a_p5 = '0;
    spot_pkg::t_coord i_b_p0 = '0;
    spot_pkg::t_coord i_b_p1 = '0;
    spot_pkg::t_coord i_b_p2 = '0;
    spot_pkg::t_coord i_b_p3 = '0;
    logic             o_result_valid;
    logic             o_overlap;

    bit          expected_overlaps[$];
    t_shape_pair bus_pair;
    int          idle_pct = 0;
    int          n_requests = 0;
    int          n_results = 0;
    int          n_hits = 0;
    int          n_errors = 0;
    int          cycle_count = 0;

    shape_pair_overlap_test_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_shape_a_kind (i_shape_a_kind),
        .i_shape_b_kind (i_shape_b_kind),
        .i_a_p0         (i_a_p0),
        .i_a_p1         (i_a_p1),
        .i_a_p2         (i_a_p2),
        .i_a_p3         (i_a_p3),
        .i_a_p4         (i_a_p4),
        .i_a_p5         (i_a_p5),
        .i_b_p0         (i_b_p0),
        .i_b_p1         (i_b_p1),
        .i_b_p2         (i_b_p2),
        .i_b_p3         (i_b_p3),
        .o_result_valid (o_result_valid),
        .o_overlap      (o_overlap)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint slot(logic [CW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint edge_cross(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
        return (px - rx) * (qy - ry) - (qx - rx) * (py - ry);
    endfunction

    function automatic bit predict_overlap(t_shape_pair p);
        longint a[6];
        longint b[4];
        longint t[6];
        longint d[3];
        longint rx, ry, rw, rh, cx, cy, cr;
        longint nx, ny, dx, dy, rs, px, py;
        bit     neg, pos, hit;
        for (int i = 0; i < 6; i++) a[i] = slot(p.a[i]);
        for (int i = 0; i < 4; i++) b[i] = slot(p.b[i]);
        hit = 1'b0;
        if (p.kind_a == spot_pkg::KIND_RECT && p.kind_b == spot_pkg::KIND_RECT) begin
            hit = a[0] < b[0] + b[2] && a[0] + a[2] > b[0] &&
                  a[1] < b[1] + b[3] && a[1] + a[3] > b[1];
        end else if (p.kind_a == spot_pkg::KIND_CIRCLE &&
                     p.kind_b == spot_pkg::KIND_CIRCLE) begin
            dx  = a[0] - b[0];
            dy  = a[1] - b[1];
            rs  = a[2] + b[2];
            hit = dx * dx + dy * dy < rs * rs;
        end else if ((p.kind_a == spot_pkg::KIND_RECT && p.kind_b == spot_pkg::KIND_CIRCLE) ||
                     (p.kind_a == spot_pkg::KIND_CIRCLE && p.kind_b == spot_pkg::KIND_RECT))
        begin
            if (p.kind_a == spot_pkg::KIND_RECT) begin
                rx = a[0]; ry = a[1]; rw = a[2]; rh = a[3];
                cx = b[0]; cy = b[1]; cr = b[2];
            end else begin
                rx = b[0]; ry = b[1]; rw = b[2]; rh = b[3];
                cx = a[0]; cy = a[1]; cr = a[2];
            end
            nx  = (cx < rx + rw) ? cx : rx + rw;
            nx  = (rx > nx) ? rx : nx;
            ny  = (cy < ry + rh) ? cy : ry + rh;
            ny  = (ry > ny) ? ry : ny;
            dx  = cx - nx;
            dy  = cy - ny;
            hit = dx * dx + dy * dy < cr * cr;
        end else if (p.kind_a == spot_pkg::KIND_TRIANGLE &&
                     p.kind_b == spot_pkg::KIND_RECT) begin
            // doubled coordinates keep the rect center exact
            px = 2 * b[0] + b[2];
            py = 2 * b[1] + b[3];
            for (int i = 0; i < 6; i++) t[i] = 2 * a[i];
            d[0] = edge_cross(px, py, t[0], t[1], t[2], t[3]);
            d[1] = edge_cross(px, py, t[2], t[3], t[4], t[5]);
            d[2] = edge_cross(px, py, t[4], t[5], t[0], t[1]);
            neg = 1'b0;
            pos = 1'b0;
            for (int i = 0; i < 3; i++) begin
                if (d[i] < 0) neg = 1'b1;
                else if (d[i] > 0) pos = 1'b1;
            end
            hit = !(neg && pos);
        end
        return hit;
    endfunction

    // checks each result against the oldest expectation, then records new requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                n_results++;
                if (expected_overlaps.size() == 0) begin
                    n_errors++;
                    $display("%0t unexpected result overlap %0b", $time, o_overlap);
                end else begin
                    if (expected_overlaps[0] !== o_overlap) begin
                        n_errors++;
                        $display("%0t overlap mismatch expected %0b actual %0b",
                                 $time, expected_overlaps[0], o_overlap);
                    end
                    if (expected_overlaps[0]) n_hits++;
                    void'(expected_overlaps.pop_front());
                end
            end
            if (start && !busy) begin
                bus_pair.kind_a = i_shape_a_kind;
                bus_pair.kind_b = i_shape_b_kind;
                bus_pair.a[0] = i_a_p0;
                bus_pair.a[1] = i_a_p1;
                bus_pair.a[2] = i_a_p2;
                bus_pair.a[3] = i_a_p3;
                bus_pair.a[4] = i_a_p4;
                bus_pair.a[5] = i_a_p5;
                bus_pair.b[0] = i_b_p0;
                bus_pair.b[1] = i_b_p1;
                bus_pair.b[2] = i_b_p2;
                bus_pair.b[3] = i_b_p3;
                expected_overlaps.insert(expected_overlaps.size(),
                                         predict_overlap(bus_pair));
                n_requests++;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t timeout with %0d results outstanding", $time, expected_overlaps.size());
        $display("tb_shape_pair_overlap_test_unit failed");
        $finish;
    end

    task automatic send_pair(t_shape_pair p);
        start          <= 1'b1;
        i_shape_a_kind <= p.kind_a;
        i_shape_b_kind <= p.kind_b;
        i_a_p0         <= p.a[0];
        i_a_p1         <= p.a[1];
        i_a_p2         <= p.a[2];
        i_a_p3         <= p.a[3];
        i_a_p4         <= p.a[4];
        i_a_p5         <= p.a[5];
        i_b_p0         <= p.b[0];
        i_b_p1         <= p.b[1];
        i_b_p2         <= p.b[2];
        i_b_p3         <= p.b[3];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_overlaps.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_shape_pair mk(spot_pkg::t_kind ka, spot_pkg::t_kind kb,
                                       int a0, int a1, int a2, int a3, int a4, int a5,
                                       int b0, int b1, int b2, int b3);
        t_shape_pair p;
        p.kind_a = ka;
        p.kind_b = kb;
        p.a[0] = CW'(a0); p.a[1] = CW'(a1); p.a[2] = CW'(a2);
        p.a[3] = CW'(a3); p.a[4] = CW'(a4); p.a[5] = CW'(a5);
        p.b[0] = CW'(b0); p.b[1] = CW'(b1); p.b[2] = CW'(b2); p.b[3] = CW'(b3);
        return p;
    endfunction

    function automatic logic [CW-1:0] rand_slot(bit is_size);
        unique case ($urandom_range(0, 9))
            0: return CW'($urandom);
            1: begin
                unique case ($urandom_range(0, 3))
                    0: return {1'b1, {(CW-1){1'b0}}};
                    1: return {1'b0, {(CW-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                if (is_size) return CW'(int'($urandom_range(0, 120)) - 8);
                else return CW'(int'($urandom_range(0, 400)) - 200);
            end
        endcase
    endfunction

    function automatic t_shape_pair random_pair(spot_pkg::t_kind ka, spot_pkg::t_kind kb);
        t_shape_pair p;
        p.kind_a = ka;
        p.kind_b = kb;
        for (int i = 0; i < 6; i++) begin
            p.a[i] = rand_slot(i >= 2 && i <= 3 && ka != spot_pkg::KIND_TRIANGLE);
        end
        for (int i = 0; i < 4; i++) p.b[i] = rand_slot(i >= 2);
        return p;
    endfunction

    task automatic test_directed_cases();
        idle_pct = 0;
        send_pair(mk(spot_pkg::KIND_NONE, spot_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(spot_pkg::KIND_POLYGON, spot_pkg::KIND_POLYGON, -32768, 32767, -1, 32767,
                     -32768, -1, 32767, -32768, 32767, -32768));
        send_pair(mk(spot_pkg::t_kind'(5), spot_pkg::KIND_RECT, 0, 0, 64, 64, 0, 0,
                     16, 16, 64, 64));
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::t_kind'(6), 0, 0, 64, 64, 0, 0,
                     16, 16, 64, 64));
        send_pair(mk(spot_pkg::t_kind'(7), spot_pkg::t_kind'(7), -1, -1, -1, -1, -1, -1,
                     -1, -1, -1, -1));
        // rect pairs: overlap, touching edge, full range, negative width
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_RECT, 0, 0, 64, 64, 0, 0,
                     32, 32, 64, 64));
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_RECT, 0, 0, 64, 64, 0, 0,
                     64, 0, 64, 64));
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_RECT, -32768, -32768, 32767, 32767,
                     0, 0, 32767, 32767, 32767, 32767));
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_RECT, 100, 0, -64, 64, 0, 0,
                     50, 10, 20, 20));
        // circle pairs: exact touch in two directions, extreme radii, negative radius
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE, 0, 0, 30, 0, 0, 0,
                     40, 30, 20, 0));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE, 0, 0, 30, 0, 0, 0,
                     30, 40, 20, 0));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE, -32768, -32768, 32767, 0,
                     0, 0, 32767, 32767, 32767, 0));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE, 0, 0, -50, 0, 0, 0,
                     10, 0, -50, 0));
        // rect and circle, both orders
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_CIRCLE, 0, 0, 64, 64, 0, 0,
                     32, 32, 1, 0));
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_CIRCLE, 0, 0, 64, 64, 0, 0,
                     94, 104, 50, 0));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_RECT, 74, 32, 10, 0, 0, 0,
                     0, 0, 64, 64));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_RECT, 80, 32, 10, 0, 0, 0,
                     0, 0, 64, 64));
        // triangle against rect center: inside, outside, on edge, degenerate
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT, 0, 0, 64, 0, 0, 64,
                     8, 8, 8, 8));
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT, 0, 0, 64, 0, 0, 64,
                     64, 64, 16, 16));
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT, 0, 0, 64, 0, 0, 64,
                     16, 0, 0, 0));
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT, 5, 5, 5, 5, 5, 5,
                     5, 5, 0, 0));
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT, 0, 0, 10, 10, 20, 20,
                     30, 0, 0, 0));
        // unsupported pairings
        send_pair(mk(spot_pkg::KIND_RECT, spot_pkg::KIND_TRIANGLE, 0, 0, 64, 64, 0, 0,
                     0, 0, 64, 64));
        send_pair(mk(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_TRIANGLE, 0, 0, 64, 0, 0, 0,
                     0, 0, 64, 64));
        send_pair(mk(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_CIRCLE, 0, 0, 64, 0, 0, 64,
                     8, 8, 8, 0));
        pause_until_drained();
    endtask

    task automatic test_rect_rect(int n);
        idle_pct = 50;
        repeat (n) send_pair(random_pair(spot_pkg::KIND_RECT, spot_pkg::KIND_RECT));
        pause_until_drained();
    endtask

    task automatic test_circle_circle(int n);
        idle_pct = 33;
        repeat (n) send_pair(random_pair(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE));
        pause_until_drained();
    endtask

    task automatic test_rect_circle(int n);
        idle_pct = 0;
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                send_pair(random_pair(spot_pkg::KIND_RECT, spot_pkg::KIND_CIRCLE));
            end else begin
                send_pair(random_pair(spot_pkg::KIND_CIRCLE, spot_pkg::KIND_RECT));
            end
        end
        pause_until_drained();
    endtask

    task automatic test_triangle_rect(int n);
        idle_pct = 50;
        repeat (n) send_pair(random_pair(spot_pkg::KIND_TRIANGLE, spot_pkg::KIND_RECT));
        pause_until_drained();
    endtask

    task automatic test_mixed_kinds(int n);
        idle_pct = 33;
        repeat (n) send_pair(random_pair(spot_pkg::t_kind'($urandom_range(0, 7)),
                                         spot_pkg::t_kind'($urandom_range(0, 7))));
        pause_until_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_rect_rect(200);
        test_circle_circle(200);
        test_rect_circle(250);
        test_triangle_rect(250);
        test_mixed_kinds(250);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_overlaps.size() != 0) begin
            n_errors++;
            $display("%0t %0d expected results never arrived", $time, expected_overlaps.size());
        end
        $display("covered every kind pairing, invalid kinds and extreme coordinates");
        $display("%0d requests, %0d results checked, %0d overlaps, %0d errors",
                 n_requests, n_results, n_hits, n_errors);
        if (n_errors == 0) begin
            $display("tb_shape_pair_overlap_test_unit passed");
        end else begin
            $display("tb_shape_pair_overlap_test_unit failed");
        end
        $finish;
    end

endmodule

// ===== shape_pair_overlap_test_unit.f =====
hdl/spot_pkg.sv
hdl/spot_rect_rect.sv
hdl/spot_circ.sv
hdl/spot_tri.sv
hdl/shape_pair_overlap_test_unit.sv
hdl/spot_checker.sv
test/tb_shape_pair_overlap_test_unit.sv
